FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Field widths of one transfer
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int OCC_BITS     = 7;
    localparam int CAPACITY_DEF = 64;

    // Operation codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                    action;
        logic [KEY_BITS-1:0]     entry_key;
        logic [PAYLOAD_BITS-1:0] entry_payload;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [OCC_BITS-1:0]     occupancy;
    } t_out_item;

    // Contents of one cell of the chain
    typedef struct packed {
        logic                    valid;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Per-cycle command broadcast to all cells
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

FILE: sv/spq_cell.sv
// One cell of the sorted chain: holds an entry, shifts toward head or tail.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_prev,
    input  logic       i_prev_gt,
    input  t_entry     i_next,
    output t_entry     o_entry,
    output logic       o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    // Held entry outranks the incoming one: it stays in front
    assign o_gt    = r_entry.valid && (r_entry.key > i_new.key);
    assign o_entry = r_entry;

    // Enqueue: keep, take the new entry, or shift from the previous cell.
    // Dequeue: pull from the next cell.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (o_gt) begin
                n_entry = r_entry;
            end else if (i_prev_gt) begin
                n_entry = i_new;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_next;
        end
    end

    // Entry register; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        r_entry.key     <= n_entry.key;
        r_entry.payload <= n_entry.payload;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

endmodule

FILE: sv/sorted_insert_priority_queue.sv
// A result is valid in the cycle after its input transfer. Throughput: one
// operation per cycle unless stalled; every cell compares and shifts at once,
// and the output register is the only stage between the two channels. The
// next input transfer waits only while a result is held by output stall.
// Reset clears the entry count, all cell valid bits and the output valid.
`timescale 1ns / 1ps

module sorted_insert_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             r_out_valid;
    t_out_item        r_out_data;
    t_out_item        n_out_data;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             in_xfer;
    logic             full;
    logic             empty;
    t_cell_ctrl       ctrl;
    t_entry           new_entry;
    t_entry           cell_q  [CAPACITY];
    logic             cell_gt [CAPACITY];

    // Handshake
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    assign ctrl.enq = in_xfer && (i_in_data.action == ACT_ENQ) && !full;
    assign ctrl.deq = in_xfer && (i_in_data.action == ACT_DEQ) && !empty;

    assign new_entry.valid   = 1'b1;
    assign new_entry.key     = i_in_data.entry_key;
    assign new_entry.payload = i_in_data.entry_payload;

    // Chain of cells, highest priority in cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry prev_e;
        t_entry next_e;
        logic   prev_gt;

        if (g == 0) begin : g_head
            assign prev_e  = '0;
            assign prev_gt = 1'b1;
        end else begin : g_body
            assign prev_e  = cell_q[g-1];
            assign prev_gt = cell_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_link
            assign next_e = cell_q[g+1];
        end

        spq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_new    (new_entry),
            .i_prev   (prev_e),
            .i_prev_gt(prev_gt),
            .i_next   (next_e),
            .o_entry  (cell_q[g]),
            .o_gt     (cell_gt[g])
        );
    end

    // Result and count update
    always_comb begin
        n_count                = r_count;
        n_out_data.status      = ST_OK;
        n_out_data.out_key     = '0;
        n_out_data.out_payload = '0;
        if (i_in_data.action == ACT_ENQ) begin
            if (full) begin
                n_out_data.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_out_data.status = ST_EMPTY;
            end else begin
                n_count                = r_count - CNT_W'(1);
                n_out_data.out_key     = cell_q[0].key;
                n_out_data.out_payload = cell_q[0].payload;
            end
        end
        n_out_data.occupancy = OCC_BITS'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the sorted-insert priority queue: directed and random operations.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // Shadow copy of the queue contents, sorted ascending by key
    logic [KEY_BITS-1:0]     pq_keys     [CAPACITY_DEF];
    logic [PAYLOAD_BITS-1:0] pq_payloads [CAPACITY_DEF];
    int                      pq_count;

    t_out_item expected_results[$];
    int        mismatches;
    int        cycle_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        rx_hold_go;
    int        rx_hold_left;

    sorted_insert_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Apply one operation to the shadow queue and return the result it should produce
    function automatic t_out_item pq_apply(input t_in_item op);
        t_out_item res;
        int        pos;
        res        = '0;
        res.status = ST_OK;
        if (op.action == ACT_ENQ) begin
            if (pq_count >= CAPACITY_DEF) begin
                res.status = ST_FULL;
            end else begin
                // walk the new entry down past strictly greater keys
                pos = pq_count;
                while (pos > 0 && pq_keys[pos-1] > op.entry_key) begin
                    pq_keys[pos]     = pq_keys[pos-1];
                    pq_payloads[pos] = pq_payloads[pos-1];
                    pos--;
                end
                pq_keys[pos]     = op.entry_key;
                pq_payloads[pos] = op.entry_payload;
                pq_count++;
            end
        end else if (pq_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            pq_count--;
            res.out_key     = pq_keys[pq_count];
            res.out_payload = pq_payloads[pq_count];
        end
        res.occupancy = OCC_BITS'(pq_count);
        return res;
    endfunction

    function automatic t_in_item make_op(input logic act, input logic [KEY_BITS-1:0] key,
                                         input logic [PAYLOAD_BITS-1:0] payload);
        t_in_item op;
        op.action        = act;
        op.entry_key     = key;
        op.entry_payload = payload;
        return op;
    endfunction

    // Random operation; keys lean toward a narrow range so equal keys are common
    function automatic t_in_item random_op(input int enq_pct);
        t_in_item op;
        op.action = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
        case ($urandom_range(3))
            0: op.entry_key = KEY_BITS'($urandom_range(7));
            1: op.entry_key = $urandom_range(1) ? {KEY_BITS{1'b1}} : {KEY_BITS{1'b0}};
            default: op.entry_key = KEY_BITS'($urandom);
        endcase
        op.entry_payload = $urandom;
        return op;
    endfunction

    // Offer one operation, hold it until the transfer, then record its expected result
    task automatic send_op(input t_in_item op);
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(pq_apply(op));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall, or a long hold-off when requested
    initial begin
        rx_hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_go) begin
                rx_hold_go   = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Result checker: each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", o_out_data);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    mismatches++;
                end
                if (o_out_data.out_key !== want.out_key) begin
                    $error("out_key: expected %h, got %h", want.out_key, o_out_data.out_key);
                    mismatches++;
                end
                if (o_out_data.out_payload !== want.out_payload) begin
                    $error("out_payload: expected %h, got %h",
                           want.out_payload, o_out_data.out_payload);
                    mismatches++;
                end
                if (o_out_data.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, o_out_data.occupancy);
                    mismatches++;
                end
            end
        end
    end

    // Dequeue on an empty queue, with nonzero and zero ignored fields
    task automatic test_dequeue_empty();
        send_op(make_op(ACT_DEQ, {KEY_BITS{1'b1}}, {PAYLOAD_BITS{1'b1}}));
        send_op(make_op(ACT_DEQ, '0, '0));
        wait_drained();
    endtask

    // Extreme keys and payloads come back highest key first
    task automatic test_extreme_keys();
        send_op(make_op(ACT_ENQ, 16'h0000, 32'h0000_0000));
        send_op(make_op(ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF));
        send_op(make_op(ACT_ENQ, 16'h8000, 32'h8000_0000));
        send_op(make_op(ACT_ENQ, 16'h7FFF, 32'h7FFF_FFFF));
        repeat (4) send_op(make_op(ACT_DEQ, 16'h5A5A, 32'hA5A5_A5A5));
        wait_drained();
    endtask

    // Equal keys: newest leaves first; neighbors on both sides
    task automatic test_equal_keys();
        send_op(make_op(ACT_ENQ, 16'd5, 32'd1));
        send_op(make_op(ACT_ENQ, 16'd5, 32'd2));
        send_op(make_op(ACT_ENQ, 16'd5, 32'd3));
        send_op(make_op(ACT_ENQ, 16'd4, 32'd4));
        send_op(make_op(ACT_ENQ, 16'd6, 32'd5));
        repeat (6) send_op(make_op(ACT_DEQ, '0, '0));
        wait_drained();
    endtask

    // Fill to capacity, overflow twice, then empty and underflow
    task automatic test_fill_and_overflow();
        t_in_item op;
        for (int k = 0; k < CAPACITY_DEF + 2; k++) begin
            op        = random_op(100);
            send_op(op);
        end
        repeat (CAPACITY_DEF + 1) send_op(random_op(0));
        wait_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_output_hold();
        rx_hold_go = 1'b1;
        repeat (40) send_op(random_op(60));
        wait_drained();
    endtask

    // Random traffic in phases that push toward full, toward empty, and balanced
    task automatic test_random_traffic();
        int enq_pct;
        for (int ph = 0; ph < 14; ph++) begin
            enq_pct = (ph % 3 == 0) ? 85 : ((ph % 3 == 1) ? 20 : 50);
            // a stretch with no idling on either side
            if (ph >= 6 && ph <= 9) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 15;
                rx_idle_pct = 15;
            end
            repeat (45) send_op(random_op(enq_pct));
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        rx_hold_go  = 1'b0;
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        pq_count    = 0;
        mismatches  = 0;
        cycle_count = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_dequeue_empty();
        test_extreme_keys();
        test_equal_keys();
        test_fill_and_overflow();
        test_output_hold();
        test_random_traffic();

        // allow any stray result to show up
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_insert_priority_queue.sv
bench/tb_top.sv
